// File: hdl/priority_text_cell_compositor_defines.svh
// Assertion macros for the checker module.
`ifndef PRIORITY_TEXT_CELL_COMPOSITOR_DEFINES_SVH
`define PRIORITY_TEXT_CELL_COMPOSITOR_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PTCC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PTCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ptcc_pkg.sv
package ptcc_pkg;

  // Store geometry
  localparam int MAX_COLS   = 128;
  localparam int MAX_ROWS   = 64;
  localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
  localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

  // Signed width for screen coordinates: 16-bit world minus camera plus half size
  localparam int POS_W = 18;

  // Function codes
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_DRAW  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  // Result status codes
  localparam logic [2:0] STATUS_DRAWN   = 3'd0;
  localparam logic [2:0] STATUS_HIDDEN  = 3'd1;
  localparam logic [2:0] STATUS_CLIPPED = 3'd2;
  localparam logic [2:0] STATUS_READ    = 3'd3;
  localparam logic [2:0] STATUS_CLEARED = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_SCREEN_COLS = 2'd0;
  localparam logic [1:0] CFG_SCREEN_ROWS = 2'd1;
  localparam logic [1:0] CFG_CAMERA_X    = 2'd2;
  localparam logic [1:0] CFG_CAMERA_Y    = 2'd3;

  typedef struct packed {
    logic [7:0]         chr;
    logic [15:0]        color;
    logic signed [15:0] prio;
  } cell_t;

  localparam cell_t CELL_BLANK = '{chr: 8'd32, color: 16'd0, prio: -16'sd1};

  // One item after screen mapping
  typedef struct packed {
    logic              valid;
    logic [1:0]        func;
    logic              clip;
    logic [ADDR_W-1:0] addr;
    cell_t             payload;
  } item_t;

  // Clamp a configured screen size into 1 .. maxv
  function automatic logic signed [POS_W-1:0] clamp_size(input logic [7:0] v, input int maxv);
    logic signed [POS_W-1:0] s;
    if (v == 8'd0) begin
      s = POS_W'(1);
    end else if (int'(v) > maxv) begin
      s = POS_W'(maxv);
    end else begin
      s = POS_W'(v);
    end
    return s;
  endfunction

endpackage

// File: hdl/ptcc_map.sv
module ptcc_map (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      load,
  input  logic [1:0]                in_func,
  input  logic signed [15:0]        in_pos_x,
  input  logic signed [15:0]        in_pos_y,
  input  logic [7:0]                in_char_code,
  input  logic [15:0]               in_color,
  input  logic signed [15:0]        in_priority_req,
  input  logic [7:0]                screen_cols,
  input  logic [6:0]                screen_rows,
  input  logic signed [15:0]        camera_x,
  input  logic signed [15:0]        camera_y,
  output ptcc_pkg::item_t           item_o
);

  logic signed [ptcc_pkg::POS_W-1:0] cols;
  logic signed [ptcc_pkg::POS_W-1:0] rows;
  logic signed [ptcc_pkg::POS_W-1:0] px;
  logic signed [ptcc_pkg::POS_W-1:0] py;
  logic signed [ptcc_pkg::POS_W-1:0] cx;
  logic signed [ptcc_pkg::POS_W-1:0] cy;
  logic signed [ptcc_pkg::POS_W-1:0] sel_x;
  logic signed [ptcc_pkg::POS_W-1:0] sel_y;
  logic                              clip;
  logic [ptcc_pkg::ADDR_W-1:0]       addr;
  ptcc_pkg::item_t                   item_r;
  ptcc_pkg::item_t                   item_nxt;

  // Sign-extend positions and camera
  assign px = {{(ptcc_pkg::POS_W-16){in_pos_x[15]}}, in_pos_x};
  assign py = {{(ptcc_pkg::POS_W-16){in_pos_y[15]}}, in_pos_y};
  assign cx = {{(ptcc_pkg::POS_W-16){camera_x[15]}}, camera_x};
  assign cy = {{(ptcc_pkg::POS_W-16){camera_y[15]}}, camera_y};

  assign cols = ptcc_pkg::clamp_size(screen_cols, ptcc_pkg::MAX_COLS);
  assign rows = ptcc_pkg::clamp_size({1'b0, screen_rows}, ptcc_pkg::MAX_ROWS);

  // Map world to screen for draws; reads give the screen cell directly
  always_comb begin
    if (in_func == ptcc_pkg::FUNC_DRAW) begin
      sel_x = px - cx + (cols >>> 1);
      sel_y = py - cy + (rows >>> 1);
    end else begin
      sel_x = px;
      sel_y = py;
    end
  end

  assign clip = (sel_x < 0) || (sel_x >= cols) || (sel_y < 0) || (sel_y >= rows);

  assign addr = ptcc_pkg::ADDR_W'(sel_y[ptcc_pkg::ROW_W-1:0])
              * ptcc_pkg::ADDR_W'(ptcc_pkg::MAX_COLS)
              + ptcc_pkg::ADDR_W'(sel_x[ptcc_pkg::COL_W-1:0]);

  always_comb begin
    item_nxt               = item_r;
    item_nxt.valid         = load && (in_func != ptcc_pkg::FUNC_NONE);
    item_nxt.func          = in_func;
    item_nxt.clip          = clip;
    item_nxt.addr          = addr;
    item_nxt.payload.chr   = in_char_code;
    item_nxt.payload.color = in_color;
    item_nxt.payload.prio  = in_priority_req;
  end

  // Advance the mapping stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else if (en) begin
      item_r <= item_nxt;
    end
  end

  assign item_o = item_r;

endmodule

// File: hdl/ptcc_store.sv
module ptcc_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [ptcc_pkg::ADDR_W-1:0]   rd_addr,
  output ptcc_pkg::cell_t               rd_data,
  input  logic                          wr_en,
  input  logic [ptcc_pkg::ADDR_W-1:0]   wr_addr,
  input  ptcc_pkg::cell_t               wr_data
);

  ptcc_pkg::cell_t mem [ptcc_pkg::CELL_COUNT];
  ptcc_pkg::cell_t mem_q_r;
  ptcc_pkg::cell_t fwd_data_r;
  logic            fwd_r;

  // Write port, and read port with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r    <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // Note a write to the entry being read in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : mem_q_r;

endmodule

// File: hdl/priority_text_cell_compositor.sv
// Character-cell frame store with a priority test. Draw and read transactions
// flow through a three-stage pipeline (screen mapping, cell read, priority test
// and write-back) and are accepted one per cycle while the output is not stalled
// and no clear or store sweep is in flight. A result passes the mapping
// register, the read register and the output register, where it is held while the
// consumer stalls. A write to the cell read by the next transaction is forwarded
// around the cell memory. A clear transaction stops input from its acceptance
// until its result: the pipeline drains, then the store is swept one cell per
// cycle through the memory's only write port, covering every cell of the
// 128 x 64 store. After reset the same sweep runs with input held off;
// configuration writes are taken at any time.
module priority_text_cell_compositor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic [7:0]         in_char_code,
  input  logic [15:0]        in_color,
  input  logic signed [15:0] in_priority_req,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [7:0]         out_cell_char,
  output logic [15:0]        out_cell_color,
  output logic signed [15:0] out_cell_priority,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  localparam logic [1:0] ST_RUN     = 2'd0;
  localparam logic [1:0] ST_SWEEP   = 2'd1;
  localparam logic [1:0] ST_CLR_OUT = 2'd2;

  localparam logic [ptcc_pkg::ADDR_W-1:0] SWEEP_LAST =
    ptcc_pkg::ADDR_W'(ptcc_pkg::CELL_COUNT - 1);

  logic [7:0]                  screen_cols_r;
  logic [6:0]                  screen_rows_r;
  logic signed [15:0]          camera_x_r;
  logic signed [15:0]          camera_y_r;

  logic [1:0]                  state_r;
  logic [1:0]                  state_nxt;
  logic                        clr_pend_r;
  logic                        clr_pend_nxt;
  logic [ptcc_pkg::ADDR_W-1:0] sweep_r;
  logic [ptcc_pkg::ADDR_W-1:0] sweep_nxt;

  ptcc_pkg::item_t             s1;
  ptcc_pkg::item_t             s2_r;
  ptcc_pkg::cell_t             cur;
  logic                        adv;
  logic                        accept;
  logic                        hidden;
  logic                        s2_draw_wr;
  logic                        s2_result;

  logic                        wr_en;
  logic [ptcc_pkg::ADDR_W-1:0] wr_addr;
  ptcc_pkg::cell_t             wr_data;

  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic                        out_load;
  logic [2:0]                  status_r;
  logic [2:0]                  status_nxt;
  ptcc_pkg::cell_t             res_r;
  ptcc_pkg::cell_t             res_nxt;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_cols_r <= 8'd80;
      screen_rows_r <= 7'd25;
      camera_x_r    <= 16'sd0;
      camera_y_r    <= 16'sd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ptcc_pkg::CFG_SCREEN_COLS: screen_cols_r <= cfg_wdata[7:0];
        ptcc_pkg::CFG_SCREEN_ROWS: screen_rows_r <= cfg_wdata[6:0];
        ptcc_pkg::CFG_CAMERA_X:    camera_x_r    <= cfg_wdata;
        ptcc_pkg::CFG_CAMERA_Y:    camera_y_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline moves when the output register is free or being emptied
  assign adv = !out_valid_r || out_ready;

  // Hold input off while a clear is in flight or the store is swept
  assign in_ready = (state_r == ST_RUN) && adv
                  && !(s1.valid && (s1.func == ptcc_pkg::FUNC_CLEAR))
                  && !(s2_r.valid && (s2_r.func == ptcc_pkg::FUNC_CLEAR));
  assign accept = in_valid && in_ready;

  ptcc_map u_map (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (adv),
    .load            (accept),
    .in_func         (in_func),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_char_code    (in_char_code),
    .in_color        (in_color),
    .in_priority_req (in_priority_req),
    .screen_cols     (screen_cols_r),
    .screen_rows     (screen_rows_r),
    .camera_x        (camera_x_r),
    .camera_y        (camera_y_r),
    .item_o          (s1)
  );

  ptcc_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (adv),
    .rd_addr (s1.addr),
    .rd_data (cur),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Advance the read stage alongside the memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else if (adv) begin
      s2_r <= s1;
    end
  end

  // Priority test and write-back
  assign hidden     = cur.prio > s2_r.payload.prio;
  assign s2_result  = adv && s2_r.valid && (s2_r.func != ptcc_pkg::FUNC_CLEAR);
  assign s2_draw_wr = s2_result && (s2_r.func == ptcc_pkg::FUNC_DRAW)
                    && !s2_r.clip && !hidden;

  always_comb begin
    if (state_r == ST_SWEEP) begin
      wr_en   = 1'b1;
      wr_addr = sweep_r;
      wr_data = ptcc_pkg::CELL_BLANK;
    end else begin
      wr_en   = s2_draw_wr;
      wr_addr = s2_r.addr;
      wr_data = s2_r.payload;
    end
  end

  // Sequence clear sweeps
  always_comb begin
    state_nxt    = state_r;
    clr_pend_nxt = clr_pend_r;
    sweep_nxt    = sweep_r;
    case (state_r)
      ST_RUN: begin
        if (adv && s2_r.valid && (s2_r.func == ptcc_pkg::FUNC_CLEAR)) begin
          state_nxt    = ST_SWEEP;
          clr_pend_nxt = 1'b1;
          sweep_nxt    = '0;
        end
      end
      ST_SWEEP: begin
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == SWEEP_LAST) begin
          state_nxt = clr_pend_r ? ST_CLR_OUT : ST_RUN;
        end
      end
      ST_CLR_OUT: begin
        if (adv) begin
          state_nxt    = ST_RUN;
          clr_pend_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_SWEEP;
      clr_pend_r <= 1'b0;
      sweep_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_pend_r <= clr_pend_nxt;
      sweep_r    <= sweep_nxt;
    end
  end

  // Build the result transaction
  always_comb begin
    status_nxt = ptcc_pkg::STATUS_CLEARED;
    res_nxt    = '0;
    out_load   = 1'b0;
    if ((state_r == ST_CLR_OUT) && adv) begin
      out_load = 1'b1;
    end else if ((state_r == ST_RUN) && s2_result) begin
      out_load = 1'b1;
      if (s2_r.clip) begin
        status_nxt = ptcc_pkg::STATUS_CLIPPED;
      end else if (s2_r.func == ptcc_pkg::FUNC_READ) begin
        status_nxt = ptcc_pkg::STATUS_READ;
        res_nxt    = cur;
      end else if (hidden) begin
        status_nxt = ptcc_pkg::STATUS_HIDDEN;
      end else begin
        status_nxt = ptcc_pkg::STATUS_DRAWN;
      end
    end
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_ready);

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status_r <= status_nxt;
      res_r    <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_cell_char     = res_r.chr;
  assign out_cell_color    = res_r.color;
  assign out_cell_priority = res_r.prio;

endmodule

// File: hdl/ptcc_checker.sv
`include "priority_text_cell_compositor_defines.svh"

module ptcc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         in_func,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_status,
  input logic [7:0]         out_cell_char,
  input logic [15:0]        out_cell_color,
  input logic signed [15:0] out_cell_priority
);

  // Stalled result holds
  `PTCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_cell_char) && $stable(out_cell_color) && $stable(out_cell_priority), "result changed while stalled")

  // Only a completed read carries cell contents
  `PTCC_ASSERT_SAME(a_zero_fields, out_valid && (out_status != ptcc_pkg::STATUS_READ), (out_cell_char == 8'd0) && (out_cell_color == 16'd0) && (out_cell_priority == 16'sd0), "non-read result carries cell data")

  // A clear stops further input at once
  `PTCC_ASSERT_NEXT(a_clear_blocks, in_valid && in_ready && (in_func == ptcc_pkg::FUNC_CLEAR), !in_ready, "input taken right after a clear")

  // Store sweep after reset holds input off
  `PTCC_ASSERT_SAME(a_reset_sweep, $rose(rst_n), !in_ready, "input taken before the store was swept")

endmodule

bind priority_text_cell_compositor ptcc_checker u_ptcc_checker (.*);

// File: sim/tb_priority_text_cell_compositor.sv
`timescale 1ns / 100ps

module tb_priority_text_cell_compositor;
  import ptcc_pkg::*;

  // One draw, read or clear request as offered on the input channel
  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         chr;
    logic [15:0]        color;
    logic signed [15:0] prio;
  } cell_op_t;

  // One result transaction
  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         chr;
    logic [15:0]        color;
    logic signed [15:0] prio;
  } cell_result_t;

  localparam int NUM_PHASES     = 7;
  localparam int DRAIN_CYCLES   = 10;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int HOLDOFF_AFTER  = 150;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_func = FUNC_NONE;
  logic signed [15:0] in_pos_x = '0;
  logic signed [15:0] in_pos_y = '0;
  logic [7:0]         in_char_code = '0;
  logic [15:0]        in_color = '0;
  logic signed [15:0] in_priority_req = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_status;
  logic [7:0]         out_cell_char;
  logic [15:0]        out_cell_color;
  logic signed [15:0] out_cell_priority;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_wdata = '0;

  // Predicted frame store and registers
  logic [7:0]         model_chr [CELL_COUNT];
  logic [15:0]        model_color [CELL_COUNT];
  logic signed [15:0] model_prio [CELL_COUNT];
  logic [7:0]         reg_cols = 8'd80;
  logic [6:0]         reg_rows = 7'd25;
  logic signed [15:0] reg_cam_x = '0;
  logic signed [15:0] reg_cam_y = '0;

  cell_op_t     cell_ops_q [$];
  cell_result_t cell_results_q [$];
  cell_op_t     cur_op;
  int           ops_queued = 0;
  int           ops_accepted = 0;
  int           mismatch_count = 0;
  int           burst_left = 0;
  int           idle_left = 0;
  int           holdoff_left = 0;
  logic         holdoff_done = 1'b0;
  logic [7:0]   stall_mask = 8'hFF;
  logic [2:0]   stall_phase = '0;
  int           stall_timer = 0;

  priority_text_cell_compositor u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_char_code      (in_char_code),
    .in_color          (in_color),
    .in_priority_req   (in_priority_req),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_cell_char     (out_cell_char),
    .out_cell_color    (out_cell_color),
    .out_cell_priority (out_cell_priority),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Blank every cell of the whole store
  function automatic void blank_store();
    for (int i = 0; i < CELL_COUNT; i++) begin
      model_chr[i]   = 8'd32;
      model_color[i] = '0;
      model_prio[i]  = -16'sd1;
    end
  endfunction

  // Screen size in use, with 0 acting as 1 and oversize acting as the store size
  function automatic int eff_cols();
    if (reg_cols == '0) return 1;
    if (int'(reg_cols) > MAX_COLS) return MAX_COLS;
    return int'(reg_cols);
  endfunction

  function automatic int eff_rows();
    if (reg_rows == '0) return 1;
    if (int'(reg_rows) > MAX_ROWS) return MAX_ROWS;
    return int'(reg_rows);
  endfunction

  // Apply one request to the predicted store; returns 0 when no result follows
  function automatic bit compose_cell(input cell_op_t op, output cell_result_t res);
    int cols;
    int rows;
    int sx;
    int sy;
    int addr;
    cols = eff_cols();
    rows = eff_rows();
    res = '0;
    case (op.func)
      FUNC_CLEAR: begin
        blank_store();
        res.status = STATUS_CLEARED;
      end
      FUNC_DRAW: begin
        sx = int'(op.pos_x) - int'(reg_cam_x) + cols / 2;
        sy = int'(op.pos_y) - int'(reg_cam_y) + rows / 2;
        if (sx < 0 || sx >= cols || sy < 0 || sy >= rows) begin
          res.status = STATUS_CLIPPED;
        end else begin
          addr = sy * MAX_COLS + sx;
          if (model_prio[addr] > op.prio) begin
            res.status = STATUS_HIDDEN;
          end else begin
            model_chr[addr]   = op.chr;
            model_color[addr] = op.color;
            model_prio[addr]  = op.prio;
            res.status = STATUS_DRAWN;
          end
        end
      end
      FUNC_READ: begin
        sx = int'(op.pos_x);
        sy = int'(op.pos_y);
        if (sx < 0 || sx >= cols || sy < 0 || sy >= rows) begin
          res.status = STATUS_CLIPPED;
        end else begin
          addr = sy * MAX_COLS + sx;
          res.status = STATUS_READ;
          res.chr    = model_chr[addr];
          res.color  = model_color[addr];
          res.prio   = model_prio[addr];
        end
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic cell_op_t mk_op(input logic [1:0] func, input int x, input int y,
                                     input int chr, input int color, input int prio);
    cell_op_t op;
    op.func  = func;
    op.pos_x = 16'(x);
    op.pos_y = 16'(y);
    op.chr   = 8'(chr);
    op.color = 16'(color);
    op.prio  = 16'(prio);
    return op;
  endfunction

  // Mostly draws near the visible window and reads of it, with some noise
  function automatic cell_op_t random_cell_op();
    cell_op_t op;
    int cols;
    int rows;
    int kind;
    int sx;
    int sy;
    cols = eff_cols();
    rows = eff_rows();
    op.func  = FUNC_DRAW;
    op.pos_x = 16'($urandom);
    op.pos_y = 16'($urandom);
    op.chr   = 8'($urandom);
    op.color = 16'($urandom);
    op.prio  = ($urandom_range(0, 9) < 7) ? 16'(int'($urandom_range(0, 8)) - 4)
                                           : 16'($urandom);
    kind = $urandom_range(0, 99);
    if (kind < 3) begin
      op.func = FUNC_NONE;
    end else if (kind < 8) begin
      op.func = FUNC_DRAW;
    end else if (kind < 70) begin
      sx = int'($urandom_range(0, cols + 1)) - 1;
      sy = int'($urandom_range(0, rows + 1)) - 1;
      op.pos_x = 16'(sx + int'(reg_cam_x) - cols / 2);
      op.pos_y = 16'(sy + int'(reg_cam_y) - rows / 2);
    end else if (kind < 96) begin
      op.func  = FUNC_READ;
      op.pos_x = 16'($urandom_range(0, cols));
      op.pos_y = 16'($urandom_range(0, rows));
    end else begin
      op.func = FUNC_READ;
    end
    return op;
  endfunction

  task automatic queue_op(input cell_op_t op);
    cell_ops_q.push_back(op);
    ops_queued++;
  endtask

  // Register write over the config channel, mirrored into the predictor
  task automatic write_cfg(input logic [1:0] index, input logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      CFG_SCREEN_COLS: reg_cols  = value[7:0];
      CFG_SCREEN_ROWS: reg_rows  = value[6:0];
      CFG_CAMERA_X:    reg_cam_x = value;
      CFG_CAMERA_Y:    reg_cam_y = value;
      default: ;
    endcase
  endtask

  // Hold until every request is taken and answered, then let the pipe empty
  task automatic wait_drained();
    do @(posedge clk); while (ops_accepted != ops_queued || cell_results_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void note_mismatch(input string field, input int want, input int got);
    $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    mismatch_count++;
  endfunction

  task automatic check_cell_result();
    cell_result_t want;
    if (cell_results_q.size() == 0) begin
      $display("%0t: unexpected result, status %0d", $time, out_status);
      mismatch_count++;
      return;
    end
    want = cell_results_q.pop_front();
    if (out_status !== want.status)
      note_mismatch("status", want.status, out_status);
    if (out_cell_char !== want.chr)
      note_mismatch("cell_char", want.chr, out_cell_char);
    if (out_cell_color !== want.color)
      note_mismatch("cell_color", want.color, out_cell_color);
    if (out_cell_priority !== want.prio)
      note_mismatch("cell_priority", int'(want.prio), int'(out_cell_priority));
  endtask

  // Driver: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    cell_result_t res;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left = $urandom_range(1, 40);
      idle_left  = 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        if (compose_cell(cur_op, res)) cell_results_q.push_back(res);
        ops_accepted++;
      end
      if (idle_left != 0) begin
        idle_left--;
        in_valid <= 1'b0;
      end else if (cell_ops_q.size() != 0) begin
        cur_op = cell_ops_q.pop_front();
        in_func         <= cur_op.func;
        in_pos_x        <= cur_op.pos_x;
        in_pos_y        <= cur_op.pos_y;
        in_char_code    <= cur_op.chr;
        in_color        <= cur_op.color;
        in_priority_req <= cur_op.prio;
        in_valid        <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          idle_left  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off once traffic is under way, to back up the pipeline
  always @(posedge clk) begin
    if (!rst_n) begin
      holdoff_left <= 0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end else if (!holdoff_done && ops_accepted >= HOLDOFF_AFTER) begin
      holdoff_left <= HOLDOFF_CYCLES;
      holdoff_done <= 1'b1;
    end
  end

  // Monitor: check each result, stall on a rotating mask picked anew now and then
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_cell_result();
      if (stall_timer == 0) begin
        stall_timer = 64;
        stall_mask  = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      end
      stall_timer--;
      stall_phase = stall_phase + 3'd1;
      out_ready <= (holdoff_left == 0) && stall_mask[stall_phase];
    end
  end

  // Stimulus: one directed phase at the reset geometry, then random phases
  initial begin
    logic [15:0] set_cols;
    logic [15:0] set_rows;
    logic [15:0] set_cam_x;
    logic [15:0] set_cam_y;
    int          n_items;
    int          clear_at;
    blank_store();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          set_cols = 16'd80; set_rows = 16'd25; set_cam_x = 16'd0; set_cam_y = 16'd0;
        end
        2: begin
          set_cols = 16'd1; set_rows = 16'd1; set_cam_x = 16'h8000; set_cam_y = 16'h7FFF;
        end
        3: begin
          set_cols = 16'hFFFF; set_rows = 16'hFFFF;
          set_cam_x = 16'h7FFF; set_cam_y = 16'h8000;
        end
        4: begin
          set_cols = 16'd0; set_rows = 16'd0; set_cam_x = 16'd5; set_cam_y = 16'hFFFD;
        end
        5: begin
          set_cols  = 16'($urandom_range(1, MAX_COLS));
          set_rows  = 16'($urandom_range(1, MAX_ROWS));
          set_cam_x = 16'(int'($urandom_range(0, 400)) - 200);
          set_cam_y = 16'(int'($urandom_range(0, 400)) - 200);
        end
        default: begin
          set_cols = 16'd128; set_rows = 16'd64; set_cam_x = 16'd0; set_cam_y = 16'd0;
        end
      endcase
      write_cfg(CFG_SCREEN_COLS, set_cols);
      write_cfg(CFG_SCREEN_ROWS, set_rows);
      write_cfg(CFG_CAMERA_X, set_cam_x);
      write_cfg(CFG_CAMERA_Y, set_cam_y);
      if (p == 0) begin
        // 80 x 25 with the camera at the origin: world (0,0) lands on (40,12)
        queue_op(mk_op(FUNC_READ, 0, 0, 0, 0, 0));
        queue_op(mk_op(FUNC_DRAW, 0, 0, 0, 'hFFFF, 0));
        queue_op(mk_op(FUNC_DRAW, 0, 0, 1, 1, -1));
        queue_op(mk_op(FUNC_DRAW, 0, 0, 'hFF, 0, 0));
        queue_op(mk_op(FUNC_DRAW, 0, 0, 'h41, 'h1234, 32767));
        queue_op(mk_op(FUNC_DRAW, 0, 0, 'h42, 'h5678, -32768));
        queue_op(mk_op(FUNC_READ, 40, 12, 0, 0, 0));
        // blank cells carry priority minus one
        queue_op(mk_op(FUNC_DRAW, -40, -12, 'h43, 'hAAAA, -32768));
        queue_op(mk_op(FUNC_DRAW, -40, -12, 'h44, 'h5555, -1));
        queue_op(mk_op(FUNC_DRAW, 39, 12, 'h45, 'h00FF, 5));
        // just off each edge, and far away
        queue_op(mk_op(FUNC_DRAW, 40, 0, 'h46, 1, 0));
        queue_op(mk_op(FUNC_DRAW, -41, 0, 'h46, 1, 0));
        queue_op(mk_op(FUNC_DRAW, 0, 13, 'h46, 1, 0));
        queue_op(mk_op(FUNC_DRAW, 0, -13, 'h46, 1, 0));
        queue_op(mk_op(FUNC_DRAW, 32767, -32768, 'h46, 1, 0));
        queue_op(mk_op(FUNC_READ, 79, 24, 0, 0, 0));
        queue_op(mk_op(FUNC_READ, 80, 0, 0, 0, 0));
        queue_op(mk_op(FUNC_READ, 0, 25, 0, 0, 0));
        queue_op(mk_op(FUNC_READ, -1, 0, 0, 0, 0));
        queue_op(mk_op(FUNC_READ, -32768, 32767, 0, 0, 0));
        // unused selector gives no result
        queue_op(mk_op(FUNC_NONE, $urandom, $urandom, $urandom, $urandom, $urandom));
        queue_op(mk_op(FUNC_READ, 0, 0, 0, 0, 0));
        queue_op(mk_op(FUNC_CLEAR, 0, 0, 0, 0, 0));
        queue_op(mk_op(FUNC_READ, 40, 12, 0, 0, 0));
        queue_op(mk_op(FUNC_READ, 0, 0, 0, 0, 0));
      end else begin
        n_items  = (p == 2 || p == 4) ? 100 : ((p == 1 || p == 3) ? 250 : 350);
        clear_at = (p == 2 || p == 4 || p == 5) ? $urandom_range(0, n_items - 1) : -1;
        for (int i = 0; i < n_items; i++) begin
          if (i == clear_at) queue_op(mk_op(FUNC_CLEAR, 0, 0, 0, 0, 0));
          else queue_op(random_cell_op());
        end
      end
      wait_drained();
    end
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
